// ----- design/websocket_frame_deframer_defines.svh -----
// Assertion macros for the deframer modules; only wsd_front uses them.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/wsd_pkg.sv -----
// Types and constants of the WebSocket receive deframer.
package wsd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       new_connection;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [1:0] message_type;
    logic       last_of_message;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_PONG      = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_EMPTY_END = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CLOSE    = 2'd1,
    ERR_UNMASKED = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
  localparam logic        REG_MAX_LEN   = 1'b0;

  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_PAY  = 5'b10000
  } phase_t;

  // One classified item waiting for the output side.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key_byte;
    logic [1:0] message_type;
    logic       last;
    err_t       error_code;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- design/wsd_front.sv -----
// Header parser and classifier: accepts bytes and queues result items.
`include "websocket_frame_deframer_defines.svh"

module wsd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  wsd_pkg::in_item_t byte_item,
  input  logic [31:0]       max_len,
  input  wsd_pkg::q_stat_t  qstat,
  output logic              push,
  output wsd_pkg::cmd_t     cmd
);

  wsd_pkg::phase_t phase, phase_next, c_phase;
  logic [3:0]  hdr_cnt, hdr_cnt_next, c_cnt;
  logic        fin, fin_next, c_fin;
  logic [3:0]  opcode, opcode_next, c_op;
  logic [63:0] remaining, remaining_next, c_rem;
  logic [31:0] key, key_next, c_key;
  logic [1:0]  mphase, mphase_next, c_mphase;
  logic [3:0]  msg_op, msg_op_next, c_msg_op;
  logic        in_frag, in_frag_next, c_frag;
  logic [32:0] msg_len, msg_len_next, c_msg_len;
  logic        halted, halted_next, c_halted;

  logic        accept;
  logic [7:0]  b;
  logic        is_data, is_cont, deliver, last_byte, too_long;
  logic [32:0] base;
  logic [64:0] total;
  logic [7:0]  key_byte;

  assign byte_ready = !qstat.full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_item.rx_byte;

  // Clear everything ahead of the byte on a fresh connection.
  always_comb begin
    if (byte_item.new_connection) begin
      c_phase   = wsd_pkg::PH_HDR0;
      c_cnt     = '0;
      c_fin     = 1'b0;
      c_op      = '0;
      c_rem     = '0;
      c_key     = '0;
      c_mphase  = '0;
      c_msg_op  = '0;
      c_frag    = 1'b0;
      c_msg_len = '0;
      c_halted  = 1'b0;
    end else begin
      c_phase   = phase;
      c_cnt     = hdr_cnt;
      c_fin     = fin;
      c_op      = opcode;
      c_rem     = remaining;
      c_key     = key;
      c_mphase  = mphase;
      c_msg_op  = msg_op;
      c_frag    = in_frag;
      c_msg_len = msg_len;
      c_halted  = halted;
    end
  end

  assign is_data   = (c_op == wsd_pkg::OP_TEXT) || (c_op == wsd_pkg::OP_BIN);
  assign is_cont   = (c_op == wsd_pkg::OP_CONT) && c_frag;
  assign deliver   = is_data || is_cont;
  assign base      = is_cont ? c_msg_len : 33'd0;
  assign total     = {1'b0, c_rem} + {32'd0, base};
  assign too_long  = total > {33'd0, max_len};
  assign last_byte = (c_rem == 64'd1);

  always_comb begin
    unique case (c_mphase)
      2'd0: key_byte = c_key[31:24];
      2'd1: key_byte = c_key[23:16];
      2'd2: key_byte = c_key[15:8];
      2'd3: key_byte = c_key[7:0];
      default: key_byte = c_key[7:0];
    endcase
  end

  always_comb begin
    phase_next     = c_phase;
    hdr_cnt_next   = c_cnt;
    fin_next       = c_fin;
    opcode_next    = c_op;
    remaining_next = c_rem;
    key_next       = c_key;
    mphase_next    = c_mphase;
    msg_op_next    = c_msg_op;
    in_frag_next   = c_frag;
    msg_len_next   = c_msg_len;
    halted_next    = c_halted;
    push           = 1'b0;
    cmd            = '0;
    cmd.kind       = wsd_pkg::KIND_PAYLOAD;
    cmd.error_code = wsd_pkg::ERR_NONE;
    if (accept && !c_halted) begin
      unique case (c_phase)
        wsd_pkg::PH_HDR0: begin
          fin_next    = b[7];
          opcode_next = b[3:0];
          phase_next  = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          if (c_op == wsd_pkg::OP_CLOSE) begin
            halted_next    = 1'b1;
            push           = 1'b1;
            cmd.kind       = wsd_pkg::KIND_ERROR;
            cmd.error_code = wsd_pkg::ERR_CLOSE;
          end else if (!b[7]) begin
            halted_next    = 1'b1;
            push           = 1'b1;
            cmd.kind       = wsd_pkg::KIND_ERROR;
            cmd.error_code = wsd_pkg::ERR_UNMASKED;
          end else if (b[6:0] < wsd_pkg::LEN_CODE_16) begin
            remaining_next = {57'd0, b[6:0]};
            phase_next     = wsd_pkg::PH_KEY;
            hdr_cnt_next   = wsd_pkg::KEY_BYTES;
          end else begin
            remaining_next = '0;
            phase_next     = wsd_pkg::PH_EXT;
            hdr_cnt_next   = (b[6:0] == wsd_pkg::LEN_CODE_16) ?
                             wsd_pkg::EXT_BYTES_16 : wsd_pkg::EXT_BYTES_64;
          end
        end
        wsd_pkg::PH_EXT: begin
          remaining_next = {c_rem[55:0], b};
          hdr_cnt_next   = c_cnt - 4'd1;
          if (c_cnt == 4'd1) begin
            phase_next   = wsd_pkg::PH_KEY;
            hdr_cnt_next = wsd_pkg::KEY_BYTES;
          end
        end
        wsd_pkg::PH_KEY: begin
          key_next     = {c_key[23:0], b};
          hdr_cnt_next = c_cnt - 4'd1;
          if (c_cnt == 4'd1) begin
            if (too_long) begin
              halted_next    = 1'b1;
              push           = 1'b1;
              cmd.kind       = wsd_pkg::KIND_ERROR;
              cmd.error_code = wsd_pkg::ERR_TOO_LONG;
            end else begin
              if (is_data) begin
                msg_op_next  = c_op;
                in_frag_next = 1'b1;
                msg_len_next = total[32:0];
              end else if (is_cont) begin
                msg_len_next = total[32:0];
              end
              if (c_rem == 64'd0) begin
                if (deliver && c_fin) begin
                  push             = 1'b1;
                  cmd.kind         = wsd_pkg::KIND_EMPTY_END;
                  cmd.message_type = msg_op_next[1:0];
                  cmd.last         = 1'b1;
                end else if (c_op == wsd_pkg::OP_PONG && c_fin) begin
                  push     = 1'b1;
                  cmd.kind = wsd_pkg::KIND_PONG;
                end
                // Close out a finished message.
                if (deliver && c_fin) begin
                  in_frag_next = 1'b0;
                  msg_len_next = '0;
                  msg_op_next  = '0;
                end
                phase_next = wsd_pkg::PH_HDR0;
              end else begin
                phase_next  = wsd_pkg::PH_PAY;
                mphase_next = '0;
              end
            end
          end
        end
        wsd_pkg::PH_PAY: begin
          remaining_next = c_rem - 64'd1;
          mphase_next    = c_mphase + 2'd1;
          if (deliver) begin
            push             = 1'b1;
            cmd.kind         = wsd_pkg::KIND_PAYLOAD;
            cmd.raw          = b;
            cmd.key_byte     = key_byte;
            cmd.message_type = c_msg_op[1:0];
            cmd.last         = c_fin && last_byte;
          end else if (last_byte && c_op == wsd_pkg::OP_PONG && c_fin) begin
            push     = 1'b1;
            cmd.kind = wsd_pkg::KIND_PONG;
          end
          if (last_byte) begin
            if (deliver && c_fin) begin
              in_frag_next = 1'b0;
              msg_len_next = '0;
              msg_op_next  = '0;
            end
            phase_next = wsd_pkg::PH_HDR0;
          end
        end
        default: phase_next = wsd_pkg::PH_HDR0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= wsd_pkg::PH_HDR0;
      hdr_cnt   <= '0;
      fin       <= 1'b0;
      opcode    <= '0;
      remaining <= '0;
      key       <= '0;
      mphase    <= '0;
      msg_op    <= '0;
      in_frag   <= 1'b0;
      msg_len   <= '0;
      halted    <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      fin       <= fin_next;
      opcode    <= opcode_next;
      remaining <= remaining_next;
      key       <= key_next;
      mphase    <= mphase_next;
      msg_op    <= msg_op_next;
      in_frag   <= in_frag_next;
      msg_len   <= msg_len_next;
      halted    <= halted_next;
    end
  end

  `WSD_ASSERT_NOW(a_halt_quiet, accept && halted && !byte_item.new_connection, !push, "item from halted parser")
  `WSD_ASSERT_NEXT(a_err_halts, push && cmd.kind == wsd_pkg::KIND_ERROR, halted, "error did not halt")
  `WSD_ASSERT_NOW(a_no_overrun, push, !qstat.full, "push into full queue")
  `WSD_ASSERT_NOW(a_pay_count, phase == wsd_pkg::PH_PAY, remaining != 64'd0, "payload phase with no bytes due")

endmodule

// ----- design/wsd_queue.sv -----
// Two-entry queue between the parser and the output stage.
module wsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output wsd_pkg::cmd_t    head,
  output wsd_pkg::q_stat_t stat
);

  wsd_pkg::cmd_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- design/wsd_back.sv -----
// Output stage: unmasks queued items into the result register.
module wsd_back (
  input  logic               clk,
  input  logic               rst,
  input  wsd_pkg::cmd_t      head,
  input  wsd_pkg::q_stat_t   qstat,
  output logic               pop,
  output logic               event_valid,
  input  logic               event_ready,
  output wsd_pkg::out_item_t event_item
);

  assign pop = !qstat.empty && (!event_valid || event_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      event_item.kind            <= head.kind;
      event_item.data_byte       <= head.raw ^ head.key_byte;
      event_item.message_type    <= head.message_type;
      event_item.last_of_message <= head.last;
      event_item.error_code      <= head.error_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (pop) begin
      event_valid <= 1'b1;
    end else if (event_ready) begin
      event_valid <= 1'b0;
    end
  end

endmodule

// ----- design/websocket_frame_deframer.sv -----
// Top level of the WebSocket receive deframer.
//
//   channel   dir  handshake                 payload
//   byte      in   byte_valid / byte_ready   byte_item  (rx_byte, new_connection)
//   event     out  event_valid / event_ready event_item (kind, data_byte, message_type,
//                                                        last_of_message, error_code)
//   config    in   APB psel/penable/pwrite   paddr, pwdata, prdata (max_message_len)
//
// One byte is taken every cycle while the two-entry queue has room; the parser
// settles each byte, header or payload, in that cycle.
// A result reaches event_valid through a queue entry and then the output register.
// Synchronous reset clears the parser, the queue and event_valid, and sets
// max_message_len to 65536; no clearing pass is needed.
// A stalled output fills the queue, and byte_ready drops only when it is full.
module websocket_frame_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  wsd_pkg::in_item_t  byte_item,
  output logic               event_valid,
  input  logic               event_ready,
  output wsd_pkg::out_item_t event_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0]      max_len;
  logic             push, pop;
  wsd_pkg::cmd_t    cmd, head;
  wsd_pkg::q_stat_t qstat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == wsd_pkg::REG_MAX_LEN) ? max_len : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= wsd_pkg::MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == wsd_pkg::REG_MAX_LEN) begin
      max_len <= pwdata;
    end
  end

  wsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .max_len    (max_len),
    .qstat      (qstat),
    .push       (push),
    .cmd        (cmd)
  );

  wsd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  wsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_item  (event_item)
  );

endmodule

// ----- sim/deframer_checker.sv -----
// Checker for the WebSocket deframer: predicts events per byte and compares them.
`timescale 1ns / 100ps

module deframer_checker import wsd_pkg::*; #(
  parameter logic [2:0] LIMIT_ADDR = '0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_ready,
  input  in_item_t   byte_item,
  input  logic       event_valid,
  input  logic       event_ready,
  input  out_item_t  event_item,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic       pready,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output int         mismatches,
  output int         pending,
  output int         events_checked
);

  localparam int REPORT_MAX = 10;

  // Parser copy
  logic [31:0] len_limit;
  phase_t      stage;
  logic [3:0]  hdr_left;
  logic        fin;
  logic [3:0]  opc;
  logic [63:0] bytes_left;
  logic [31:0] key;
  logic [1:0]  key_idx;
  logic [3:0]  msg_op;
  logic        msg_open;
  logic [32:0] msg_len;
  logic        halted;

  out_item_t events_due[$];

  task automatic clear_parser();
    stage = PH_HDR0;
    hdr_left = '0;
    fin = 1'b0;
    opc = '0;
    bytes_left = '0;
    key = '0;
    key_idx = '0;
    msg_op = '0;
    msg_open = 1'b0;
    msg_len = '0;
    halted = 1'b0;
  endtask

  task automatic post(input kind_t k, input logic [7:0] d, input logic [1:0] t,
                      input logic l, input err_t e);
    events_due.push_back('{kind: k, data_byte: d, message_type: t,
                           last_of_message: l, error_code: e});
  endtask

  task automatic fail_conn(input err_t e);
    halted = 1'b1;
    post(KIND_ERROR, 8'h00, 2'd0, 1'b0, e);
  endtask

  function automatic logic carries_data();
    return opc == OP_TEXT || opc == OP_BIN || (opc == OP_CONT && msg_open);
  endfunction

  task automatic finish_frame();
    if (carries_data() && fin) begin
      msg_open = 1'b0;
      msg_len = '0;
      msg_op = '0;
    end
    stage = PH_HDR0;
  endtask

  // Last key byte: limit check, message bookkeeping, empty-frame events.
  task automatic header_complete();
    logic        data_frame;
    logic        cont_frame;
    logic [63:0] base;
    logic [63:0] lim;
    data_frame = opc == OP_TEXT || opc == OP_BIN;
    cont_frame = opc == OP_CONT && msg_open;
    base = cont_frame ? 64'(msg_len) : 64'd0;
    lim = 64'(len_limit);
    if (base > lim || bytes_left > lim - base) begin
      fail_conn(ERR_TOO_LONG);
      return;
    end
    if (data_frame) begin
      msg_op = opc;
      msg_open = 1'b1;
      msg_len = bytes_left[32:0];
    end else if (cont_frame) begin
      msg_len = 33'(base + bytes_left);
    end
    if (bytes_left == 0) begin
      if ((data_frame || cont_frame) && fin)
        post(KIND_EMPTY_END, 8'h00, msg_op[1:0], 1'b1, ERR_NONE);
      else if (opc == OP_PONG && fin)
        post(KIND_PONG, 8'h00, 2'd0, 1'b0, ERR_NONE);
      finish_frame();
    end else begin
      stage = PH_PAY;
      key_idx = '0;
    end
  endtask

  task automatic parse_byte(input in_item_t it);
    logic [7:0] b;
    logic [7:0] d;
    logic       pass;
    b = it.rx_byte;
    if (it.new_connection) clear_parser();
    if (halted) return;
    case (stage)
      PH_HDR0: begin
        fin = b[7];
        opc = b[3:0];
        stage = PH_HDR1;
      end
      PH_HDR1: begin
        // close wins over a missing mask bit
        if (opc == OP_CLOSE) fail_conn(ERR_CLOSE);
        else if (!b[7]) fail_conn(ERR_UNMASKED);
        else begin
          key = '0;
          if (b[6:0] < LEN_CODE_16) begin
            bytes_left = 64'(b[6:0]);
            stage = PH_KEY;
            hdr_left = KEY_BYTES;
          end else begin
            bytes_left = '0;
            stage = PH_EXT;
            hdr_left = (b[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          end
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        hdr_left--;
        if (hdr_left == 0) begin
          stage = PH_KEY;
          hdr_left = KEY_BYTES;
        end
      end
      PH_KEY: begin
        key = {key[23:0], b};
        hdr_left--;
        if (hdr_left == 0) header_complete();
      end
      PH_PAY: begin
        pass = carries_data();
        d = b ^ key[8*(3-key_idx) +: 8];
        key_idx++;
        bytes_left--;
        if (pass)
          post(KIND_PAYLOAD, d, msg_op[1:0], fin && bytes_left == 0, ERR_NONE);
        else if (bytes_left == 0 && opc == OP_PONG && fin)
          post(KIND_PONG, 8'h00, 2'd0, 1'b0, ERR_NONE);
        if (bytes_left == 0) finish_frame();
      end
      default: stage = PH_HDR0;
    endcase
  endtask

  task automatic check_event(input out_item_t got);
    out_item_t want;
    events_checked++;
    if (events_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("event %0d unexpected: kind %0d data %02h type %0d last %0d err %0d",
                 events_checked, got.kind, got.data_byte, got.message_type,
                 got.last_of_message, got.error_code);
      return;
    end
    want = events_due.pop_front();
    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
        got.message_type !== want.message_type ||
        got.last_of_message !== want.last_of_message ||
        got.error_code !== want.error_code) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("event %0d: expected kind %0d data %02h type %0d last %0d err %0d, %s",
                 events_checked, want.kind, want.data_byte, want.message_type,
                 want.last_of_message, want.error_code,
                 $sformatf("got kind %0d data %02h type %0d last %0d err %0d",
                           got.kind, got.data_byte, got.message_type,
                           got.last_of_message, got.error_code));
    end
  endtask

  // Compare before predicting: no event can leave in the cycle its byte enters.
  always @(posedge clk) begin
    if (rst) begin
      len_limit = MAX_LEN_RESET;
      clear_parser();
      events_due.delete();
    end else begin
      if (event_valid && event_ready) check_event(event_item);
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR) len_limit = pwdata;
      if (byte_valid && byte_ready) parse_byte(byte_item);
    end
    pending = events_due.size();
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the WebSocket deframer: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
  import wsd_pkg::*;

  localparam logic [2:0] LIMIT_ADDR      = {REG_MAX_LEN, 2'b00};
  localparam logic [3:0] OP_PING         = 4'h9;
  localparam logic [3:0] OP_RSVD         = 4'h3;
  localparam logic [6:0] LEN_CODE_64     = 7'd127;
  localparam int         WATCHDOG_CYCLES = 3000;
  localparam int         SETTLE_CYCLES   = 8;
  localparam int         PHASE_BYTES     = 160;

  typedef enum int {ENC_MIN, ENC_16, ENC_64} len_enc_t;

  logic       clk;
  logic       rst;
  logic       byte_valid;
  logic       byte_ready;
  in_item_t   byte_item;
  logic       event_valid;
  logic       event_ready;
  out_item_t  event_item;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;

  int mismatches;
  int pending;
  int events_checked;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          quiet_cycles;
  int          bytes_sent;
  int          frames_sent;
  int          limit_writes;
  logic        fresh;
  logic [31:0] cur_limit;

  websocket_frame_deframer i_dut (
    .clk, .rst, .byte_valid, .byte_ready, .byte_item,
    .event_valid, .event_ready, .event_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  deframer_checker #(.LIMIT_ADDR(LIMIT_ADDR)) i_check (
    .clk, .rst, .byte_valid, .byte_ready, .byte_item,
    .event_valid, .event_ready, .event_item,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .pending, .events_checked
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    event_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (event_valid && event_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_CYCLES) begin
      $display("Watchdog: no handshake for %0d cycles, %0d events outstanding",
               WATCHDOG_CYCLES, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic pace(input int s, input int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  task automatic send_byte(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= it;
    do @(posedge clk); while (!byte_ready);
  endtask

  task automatic put(input logic [7:0] b);
    in_item_t it;
    it.rx_byte = b;
    // rare stray reconnect lands anywhere in a frame
    it.new_connection = fresh || ($urandom_range(199) == 0);
    fresh = 1'b0;
    send_byte(it);
    bytes_sent++;
  endtask

  // Hold the byte side until every predicted event is out.
  task automatic drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limit(input logic [31:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_limit = v;
    limit_writes++;
  endtask

  // Header, mask key and the first body bytes; unmasked frames stop after two bytes.
  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input len_enc_t enc,
                            input int unsigned body);
    logic [6:0] code;
    if (enc == ENC_MIN && len < LEN_CODE_16) code = len[6:0];
    else if (enc != ENC_64 && len <= 64'hFFFF) code = LEN_CODE_16;
    else code = LEN_CODE_64;
    frames_sent++;
    put({fin, 3'($urandom_range(7)), op});
    put({masked, code});
    if (!masked) return;
    if (code == LEN_CODE_16) begin
      put(len[15:8]);
      put(len[7:0]);
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) put(len[8*i +: 8]);
    end
    repeat (4) put(8'($urandom));
    repeat (body) put(8'($urandom));
  endtask

  function automatic len_enc_t pick_enc();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return ENC_16;
    if (r == 1) return ENC_64;
    return ENC_MIN;
  endfunction

  // Mostly short lengths kept under the limit, some near the 7-bit boundary.
  function automatic logic [63:0] pick_len();
    int unsigned r;
    logic [63:0] l;
    r = $urandom_range(99);
    if (r < 60) l = 64'($urandom_range(8));
    else if (r < 85) l = 64'($urandom_range(9, 30));
    else if (r < 95) l = 64'($urandom_range(120, 130));
    else l = 64'd0;
    if (l > 64'(cur_limit) && $urandom_range(99) < 85)
      l = 64'($urandom_range((cur_limit > 8) ? 8 : cur_limit));
    return l;
  endfunction

  task automatic random_frame();
    int unsigned pick;
    logic [3:0]  op;
    logic [63:0] len;
    if ($urandom_range(99) < 3) drain();
    if ($urandom_range(99) < 6) fresh = 1'b1;
    pick = $urandom_range(99);
    op = $urandom_range(1) ? OP_TEXT : OP_BIN;
    len = pick_len();
    if (pick < 30) begin
      send_frame(1'($urandom_range(1)), op, 1'b1, len, pick_enc(), int'(len));
    end else if (pick < 55) begin
      send_frame(1'($urandom_range(1)), OP_CONT, 1'b1, len, pick_enc(), int'(len));
    end else if (pick < 64) begin
      len = 64'($urandom_range(6));
      send_frame($urandom_range(4) != 0, OP_PONG, 1'b1, len, pick_enc(), int'(len));
    end else if (pick < 71) begin
      op = 4'($urandom_range(3, 15));
      if (op == OP_CLOSE || op == OP_PONG) op = OP_PING;
      len = 64'($urandom_range(4));
      send_frame(1'($urandom_range(1)), op, 1'b1, len, pick_enc(), int'(len));
    end else if (pick < 75) begin
      send_frame(1'($urandom_range(1)), OP_CLOSE, 1'($urandom_range(1)), 64'd0, ENC_MIN, 0);
      fresh = 1'b1;
    end else if (pick < 79) begin
      send_frame(1'($urandom_range(1)), 4'($urandom_range(15)), 1'b0, len, ENC_MIN, 0);
      fresh = 1'b1;
    end else if (pick < 84) begin
      len = 64'(cur_limit) + 64'($urandom_range(1, 4));
      if ($urandom_range(9) == 0) len = {$urandom, $urandom} | 64'h1_0000_0000;
      send_frame(1'($urandom_range(1)), $urandom_range(1) ? op : OP_CONT, 1'b1, len,
                 $urandom_range(1) ? ENC_16 : ENC_64, 0);
      fresh = 1'b1;
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 8)) put(8'($urandom));
      fresh = 1'b1;
    end else if (pick < 94) begin
      len = 64'($urandom_range(2, 30));
      send_frame(1'($urandom_range(1)), op, 1'b1, len, pick_enc(),
                 $urandom_range(int'(len) - 1));
      fresh = 1'b1;
    end else if (cur_limit <= 64) begin
      send_frame(1'b1, op, 1'b1, 64'(cur_limit), pick_enc(), cur_limit);
    end else begin
      send_frame(1'b1, op, 1'b1, 64'(cur_limit), pick_enc(), $urandom_range(4));
      fresh = 1'b1;
    end
  endtask

  task automatic run_random(input int n);
    int stop_at;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) random_frame();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_item = '0;
    event_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fresh = 1'b0;
    cur_limit = MAX_LEN_RESET;
    pace(0, 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit, some of them longer than it
    send_frame(1'b1, OP_TEXT, 1'b1, 64'd3, ENC_MIN, 3);
    send_frame(1'b0, OP_BIN, 1'b1, 64'd2, ENC_MIN, 2);
    send_frame(1'b0, OP_CONT, 1'b1, 64'd0, ENC_MIN, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 64'd1, ENC_MIN, 1);
    send_frame(1'b1, OP_TEXT, 1'b1, 64'd0, ENC_MIN, 0);
    send_frame(1'b0, OP_BIN, 1'b1, 64'd0, ENC_MIN, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 64'd0, ENC_MIN, 0);
    send_frame(1'b1, OP_PONG, 1'b1, 64'd0, ENC_MIN, 0);
    send_frame(1'b1, OP_PONG, 1'b1, 64'd2, ENC_MIN, 2);
    send_frame(1'b0, OP_PONG, 1'b1, 64'd1, ENC_MIN, 1);
    send_frame(1'b1, OP_PING, 1'b1, 64'd2, ENC_MIN, 2);
    send_frame(1'b1, OP_RSVD, 1'b1, 64'd1, ENC_MIN, 1);
    send_frame(1'b1, OP_CONT, 1'b1, 64'd2, ENC_MIN, 2);
    // abandon an open text message for a new binary one
    send_frame(1'b0, OP_TEXT, 1'b1, 64'd2, ENC_MIN, 2);
    send_frame(1'b1, OP_BIN, 1'b1, 64'd1, ENC_MIN, 1);
    send_frame(1'b1, OP_TEXT, 1'b1, 64'd4, ENC_16, 4);
    send_frame(1'b1, OP_BIN, 1'b1, 64'd3, ENC_64, 3);
    // length equal to the limit passes the header; cut it short
    send_frame(1'b1, OP_BIN, 1'b1, 64'(MAX_LEN_RESET), ENC_64, 2);
    fresh = 1'b1;
    send_frame(1'b1, OP_TEXT, 1'b1, 64'(MAX_LEN_RESET) + 64'd1, ENC_64, 0);
    fresh = 1'b1;
    send_frame(1'b1, OP_BIN, 1'b1, 64'hFF00_0000_0000_0001, ENC_64, 0);
    fresh = 1'b1;
    send_frame(1'b1, OP_CLOSE, 1'b1, 64'd0, ENC_MIN, 0);
    // ignored while halted
    send_frame(1'b1, OP_TEXT, 1'b1, 64'd2, ENC_MIN, 2);
    fresh = 1'b1;
    send_frame(1'b1, OP_CLOSE, 1'b0, 64'd0, ENC_MIN, 0);
    fresh = 1'b1;
    send_frame(1'b1, OP_TEXT, 1'b0, 64'd2, ENC_MIN, 0);
    fresh = 1'b1;
    // leave a message open across the limit change
    send_frame(1'b0, OP_TEXT, 1'b1, 64'd5, ENC_MIN, 5);

    set_limit(32'd1);
    pace(45, 0);
    send_frame(1'b1, OP_CONT, 1'b1, 64'd0, ENC_MIN, 0);
    fresh = 1'b1;
    run_random(PHASE_BYTES);

    set_limit(32'hFFFF_FFFF);
    pace(0, 45);
    run_random(PHASE_BYTES);

    set_limit(32'd20);
    pace(24, 24);
    run_random(PHASE_BYTES);

    set_limit($urandom_range(2, 64));
    pace(0, 0);
    run_random(PHASE_BYTES);

    set_limit($urandom_range(100, 400));
    pace(45, 0);
    run_random(PHASE_BYTES);

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d bytes in %0d frames under %0d length limits, %0d events checked",
             bytes_sent, frames_sent, limit_writes + 1, events_checked);
    $display("Frames: fragments, pongs, control, truncated, bad, oversize, halts, reconnects");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/wsd_pkg.sv
design/wsd_front.sv
design/wsd_queue.sv
design/wsd_back.sv
design/websocket_frame_deframer.sv
sim/deframer_checker.sv
sim/tb.sv
